// ----- rtl/core/dsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants for the drive-straight PID block
// Field widths, fixed-point limits, the sequencer states, the interfaces of
// the constant divider, and the radix-16 digit function for division by 20.
// ----------------------------------------------------------------------------
package dsp_pkg;

    // Field widths
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 8;
    localparam int DRV_W   = 8;
    localparam int CNT_W   = 32;
    localparam int ERR_W   = CNT_W + 1;      // right - left
    localparam int DIFF_W  = ERR_W + 1;      // error - previous error
    localparam int INTEG_W = 48;
    localparam int INC_W   = ERR_W + 5;      // 20 * error
    localparam int I_LO_W  = 24;             // integral split for the multiplier
    localparam int I_HI_W  = INTEG_W - I_LO_W;

    // Shared multiplier: 17 bit signed by 34 bit signed
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = DIFF_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Correction accumulator
    localparam int ACC_W   = 66;

    // Behavior constants
    localparam int SPEED_LIMIT = 110;
    localparam int DERIV_DIV   = 20;
    localparam int DRIVE_MAX   = 127;
    localparam int CORR_SCALE  = SPEED_LIMIT * 256;        // 28160
    localparam int NSAT        = (DRIVE_MAX + 1) * CORR_SCALE;

    // Right-side numerator: speed * (CORR_SCALE - C), with the factor clamped
    // to +-M_LIM. Any clamp already saturates the drive when speed is nonzero.
    localparam int M_W    = 24;
    localparam int M_LIM  = 1 << (M_W - 2);
    localparam int N_W    = 31;
    localparam int NQ_W   = DRV_W - 1;

    // Output divide: CORR_SCALE = 512 * 55. Drop nine bits, then multiply by
    // ceil(2^19 / 55) and keep the bits above 19; exact below NSAT.
    localparam int N_SHIFT = 9;
    localparam int NX_W    = 13;
    localparam int RCP_SH  = 19;
    localparam int RCP_55  = 9533;

    // Constant divider by 20, one hex digit per cycle
    localparam int DIV_IN_W  = MUL_P_W - 1;
    localparam int DIGITS    = (DIV_IN_W + 3) / 4;
    localparam int DIVX_W    = DIGITS * 4;
    localparam int DCNT_W    = 4;
    localparam int DREM_W    = 5;
    localparam int DV_W      = DREM_W + 4;
    localparam int QDIV_W    = 46;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_GAIN_P = 2'd0,
        CFG_GAIN_I = 2'd1,
        CFG_GAIN_D = 2'd2
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INTEG,
        ST_MUL_D,
        ST_MUL_P,
        ST_MUL_IL,
        ST_MUL_IH,
        ST_ACC_IH,
        ST_WAIT_DIV,
        ST_CORR,
        ST_MUL_N,
        ST_DIV_N,
        ST_QUOT_N,
        ST_FINISH
    } st_t;

    typedef struct packed {
        logic                start;
        logic [DIV_IN_W-1:0] dividend;
    } cdiv_req_t;

    typedef struct packed {
        logic              busy;
        logic [QDIV_W-1:0] quotient;
    } cdiv_rsp_t;

    // Quotient digit of a partial remainder (below 320) divided by 20
    function automatic logic [3:0] div20_digit(input logic [DV_W-1:0] v);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (v >= DV_W'(k * DERIV_DIV))
            begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

endpackage

// ----- rtl/core/dsp_mul.sv -----
// ----------------------------------------------------------------------------
// dsp_mul: shared signed multiplier
// One 17 x 34 bit signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module dsp_mul
    import dsp_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    // Product register
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

// ----- rtl/core/dsp_cdiv.sv -----
// ----------------------------------------------------------------------------
// dsp_cdiv: divide by 20
// Long division of an unsigned magnitude by 20, one hex digit per cycle,
// most significant digit first. Busy from start until the last digit is taken.
// ----------------------------------------------------------------------------
module dsp_cdiv
    import dsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cdiv_req_t req,
    output cdiv_rsp_t rsp
);

    logic [DIVX_W-1:0] x_reg, x_next;
    logic [DIVX_W-1:0] q_reg, q_next;
    logic [DREM_W-1:0] rem_reg, rem_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DV_W-1:0]   v;
    logic [DV_W-1:0]   v_rem;
    logic [3:0]        qd;

    // Digit step: bring down the next hex digit and take out multiples of 20
    always_comb
    begin
        v     = {rem_reg, x_reg[DIVX_W-1 -: 4]};
        qd    = div20_digit(v);
        v_rem = v - ({1'b0, qd, 4'b0000} + {3'b000, qd, 2'b00});

        x_next    = x_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;

        if (req.start)
        begin
            x_next    = DIVX_W'(req.dividend);
            q_next    = '0;
            rem_next  = '0;
            cnt_next  = DCNT_W'(DIGITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next   = x_reg << 4;
            q_next   = {q_reg[DIVX_W-5:0], qd};
            rem_next = v_rem[DREM_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = q_reg[QDIV_W-1:0];

endmodule

// ----- rtl/core/drive_straight_pid.sv -----
// ----------------------------------------------------------------------------
// drive_straight_pid: straight-line drive correction for a two-wheeled base
// A control step skips the output divide when the right drive saturates; a
// clear goes from idle straight to loading the output register.
// Throughput: one item at a time; the next is taken once the result sits in
// the output register. The 13-digit divide by 20 of the derivative term sets
// most of the step time; the output divide is a reciprocal multiply.
// Reset: gains go to kp = 1.0, ki = kd = 0; integral and previous error clear.
// ----------------------------------------------------------------------------
module drive_straight_pid
    import dsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // speed[7:0], right_count[39:8], left_count[71:40]
    input  logic        s_tuser,    // cmd[0]

    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // left_drive[7:0], right_drive[15:8], saturated[16]

    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Gains
    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;

    // Sequencer and loop state
    st_t                      state_reg, state_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]  prev_reg, prev_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    // Working registers
    logic signed [ERR_W-1:0]   e_reg, e_next;
    logic signed [DIFF_W-1:0]  d_reg, d_next;
    logic signed [SPEED_W-1:0] s_reg, s_next;
    logic signed [DRV_W-1:0]   r_reg, r_next;
    logic                      sat_reg, sat_next;
    logic                      dneg_reg, dneg_next;
    logic                      nneg_reg, nneg_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [NX_W-1:0]           nx_reg, nx_next;

    // Output register
    logic signed [DRV_W-1:0] out_left_reg, out_right_reg;
    logic                    out_sat_reg;

    // Shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    cdiv_req_t                 div_req;
    cdiv_rsp_t                 div_rsp;

    // Intermediate values
    logic [CNT_W-1:0]          right_in, left_in;
    logic signed [SPEED_W-1:0] speed_in, speed_clamp;
    logic signed [ERR_W-1:0]   e_in;
    logic signed [INC_W-1:0]   inc;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [MUL_P_W-1:0] p_abs;
    logic signed [ACC_W-1:0]   div_q_ext;
    logic signed [ACC_W-1:0]   corr_diff;
    logic signed [M_W-1:0]     m_clamp;
    logic signed [N_W-1:0]     n_val, n_abs;
    logic [NQ_W-1:0]           nq;

    dsp_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    dsp_cdiv u_cdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Field unpacking and per-step arithmetic
    always_comb
    begin
        speed_in = $signed(s_tdata[SPEED_W-1:0]);
        right_in = s_tdata[SPEED_W +: CNT_W];
        left_in  = s_tdata[SPEED_W+CNT_W +: CNT_W];

        if (speed_in > SPEED_W'(SPEED_LIMIT))
        begin
            speed_clamp = SPEED_W'(SPEED_LIMIT);
        end
        else if (speed_in < -SPEED_W'(SPEED_LIMIT))
        begin
            speed_clamp = -SPEED_W'(SPEED_LIMIT);
        end
        else
        begin
            speed_clamp = speed_in;
        end

        e_in = $signed({right_in[CNT_W-1], right_in}) - $signed({left_in[CNT_W-1], left_in});

        // 20 * e as 16e + 4e
        inc       = (INC_W'(e_reg) <<< 4) + (INC_W'(e_reg) <<< 2);
        integ_sum = (INTEG_W + 1)'(integ_reg) + (INTEG_W + 1)'(inc);

        p_abs     = mul_p[MUL_P_W-1] ? -mul_p : mul_p;
        div_q_ext = $signed({{(ACC_W - QDIV_W){1'b0}}, div_rsp.quotient});

        // Right-side factor, clamped where it saturates the drive anyway
        corr_diff = ACC_W'(CORR_SCALE) - acc_reg;
        if (corr_diff > ACC_W'(M_LIM))
        begin
            m_clamp = M_W'(M_LIM);
        end
        else if (corr_diff < -ACC_W'(M_LIM))
        begin
            m_clamp = -M_W'(M_LIM);
        end
        else
        begin
            m_clamp = corr_diff[M_W-1:0];
        end

        n_val  = mul_p[N_W-1:0];
        n_abs  = n_val[N_W-1] ? -n_val : n_val;

        // Quotient of the numerator magnitude by CORR_SCALE
        nq     = mul_p[RCP_SH +: NQ_W];
    end

    // Shared multiplier operands and divider start
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_D:
            begin
                mul_a = $signed({1'b0, gain_d_reg});
                mul_b = d_reg;
            end
            ST_MUL_P:
            begin
                mul_a = $signed({1'b0, gain_p_reg});
                mul_b = MUL_B_W'(e_reg);
            end
            ST_MUL_IL:
            begin
                mul_a = $signed({1'b0, gain_i_reg});
                mul_b = $signed({{(MUL_B_W - I_LO_W){1'b0}}, integ_reg[I_LO_W-1:0]});
            end
            ST_MUL_IH:
            begin
                mul_a = $signed({1'b0, gain_i_reg});
                mul_b = MUL_B_W'($signed(integ_reg[INTEG_W-1 -: I_HI_W]));
            end
            ST_CORR:
            begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = MUL_B_W'(m_clamp);
            end
            ST_DIV_N:
            begin
                mul_a = MUL_A_W'(RCP_55);
                mul_b = $signed({{(MUL_B_W - NX_W){1'b0}}, nx_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        div_req.start    = (state_reg == ST_MUL_P);
        div_req.dividend = p_abs[DIV_IN_W-1:0];
    end

    // Sequencer: next state and register updates
    always_comb
    begin
        state_next    = state_reg;
        integ_next    = integ_reg;
        prev_next     = prev_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        e_next        = e_reg;
        d_next        = d_reg;
        s_next        = s_reg;
        r_next        = r_reg;
        sat_next      = sat_reg;
        dneg_next     = dneg_reg;
        nneg_next     = nneg_reg;
        acc_next      = acc_reg;
        nx_next       = nx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sat_next = 1'b0;
                    if (s_tuser)
                    begin
                        // Clear: zero the loop state and return zeros
                        integ_next = '0;
                        prev_next  = '0;
                        s_next     = '0;
                        r_next     = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        s_next     = speed_clamp;
                        e_next     = e_in;
                        state_next = ST_INTEG;
                    end
                end
            end
            ST_INTEG:
            begin
                // Saturating integral, derivative difference
                if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
                begin
                    integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                                     : {1'b0, {(INTEG_W - 1){1'b1}}};
                    sat_next   = 1'b1;
                end
                else
                begin
                    integ_next = integ_sum[INTEG_W-1:0];
                end
                d_next     = DIFF_W'(e_reg) - DIFF_W'(prev_reg);
                prev_next  = e_reg;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                // kd * d is ready: divider takes its magnitude
                dneg_next  = mul_p[MUL_P_W-1];
                state_next = ST_MUL_IL;
            end
            ST_MUL_IL:
            begin
                acc_next   = ACC_W'(mul_p);
                state_next = ST_MUL_IH;
            end
            ST_MUL_IH:
            begin
                acc_next   = acc_reg + ACC_W'(mul_p);
                state_next = ST_ACC_IH;
            end
            ST_ACC_IH:
            begin
                acc_next   = acc_reg + (ACC_W'(mul_p) <<< I_LO_W);
                state_next = ST_WAIT_DIV;
            end
            ST_WAIT_DIV:
            begin
                // Subtract the derivative term, truncated toward zero
                if (!div_rsp.busy)
                begin
                    acc_next   = dneg_reg ? acc_reg + div_q_ext : acc_reg - div_q_ext;
                    state_next = ST_CORR;
                end
            end
            ST_CORR:
            begin
                state_next = ST_MUL_N;
            end
            ST_MUL_N:
            begin
                nneg_next = n_val[N_W-1];
                if (n_abs >= N_W'(NSAT))
                begin
                    r_next     = n_val[N_W-1] ? -DRV_W'(DRIVE_MAX) : DRV_W'(DRIVE_MAX);
                    sat_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    nx_next    = n_abs[N_SHIFT +: NX_W];
                    state_next = ST_DIV_N;
                end
            end
            ST_DIV_N:
            begin
                // Reciprocal multiply in flight
                state_next = ST_QUOT_N;
            end
            ST_QUOT_N:
            begin
                r_next     = nneg_reg ? -$signed({1'b0, nq}) : $signed({1'b0, nq});
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and loop state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            integ_reg    <= '0;
            prev_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            integ_reg    <= integ_next;
            prev_reg     <= prev_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        d_reg    <= d_next;
        s_reg    <= s_next;
        r_reg    <= r_next;
        sat_reg  <= sat_next;
        dneg_reg <= dneg_next;
        nneg_reg <= nneg_next;
        acc_reg  <= acc_next;
        nx_reg   <= nx_next;
    end

    // Output register, loaded as the sequencer leaves ST_FINISH
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && (!m_tvalid_reg || m_tready))
        begin
            out_left_reg  <= s_reg;
            out_right_reg <= r_reg;
            out_sat_reg   <= sat_reg;
        end
    end

    // Gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_W'(256);
            gain_i_reg <= '0;
            gain_d_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P: gain_p_reg <= cfg_data;
                CFG_GAIN_I: gain_i_reg <= cfg_data;
                CFG_GAIN_D: gain_d_reg <= cfg_data;
                default:
                begin
                    gain_p_reg <= gain_p_reg;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'b0000000, out_sat_reg, out_right_reg, out_left_reg};

endmodule
